// ----- rtl/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 encoder.
package b64e_pkg;

	// Field widths fixed by the item formats
	localparam int BYTE_BITS  = 8;
	localparam int CAP_BITS   = 24;
	localparam int TOTAL_BITS = 24;

	// Counter width default for the top level
	localparam int COUNT_BITS_DEFAULT = 24;

	// Depth of the group queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Configuration port
	localparam int                  ADDR_BITS   = 3;
	localparam int                  DATA_BITS   = 32;
	localparam logic [0:0]          REG_OUTPUT_CAPACITY = 1'b0;
	localparam logic [CAP_BITS-1:0] CAP_RESET   = 24'hFFFFFF;

	// Character codes
	localparam logic [BYTE_BITS-1:0] CHAR_PAD   = 8'h3D;
	localparam logic [BYTE_BITS-1:0] CHAR_ERROR = 8'h00;

	// Input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [7:0]  out_char;
		logic        end_of_message;
		logic        overflow_error;
		logic [23:0] total_chars;
	} out_item_t;

	// One classified group handed from front to back
	typedef struct packed {
		logic [23:0] word;    // left-aligned group bytes
		logic [1:0]  nbytes;  // 1..3 bytes in the group
		logic        last;    // group closes the message
		logic        err;     // capacity check failed
	} group_t;

	// Map one sextet to its character of the standard alphabet
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] ext;
		ext = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + ext;
		end else if (v < 6'd52) begin
			return 8'h61 + ext - 8'd26;
		end else if (v < 6'd62) begin
			return 8'h30 + ext - 8'd52;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage

// ----- rtl/b64e_front.sv -----
// Front end: accepts bytes, gathers groups, runs the capacity check.
module b64e_front #(
	parameter int COUNT_BITS = b64e_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_ready,
	input  b64e_pkg::in_item_t             src_item,
	input  logic [b64e_pkg::CAP_BITS-1:0]  capacity,
	input  logic                           q_full,
	output logic                           push,
	output b64e_pkg::group_t               group,
	output logic [COUNT_BITS-1:0]          base
);

	localparam int CMP_BITS =
		((COUNT_BITS > b64e_pkg::CAP_BITS) ? COUNT_BITS : b64e_pkg::CAP_BITS) + 1;

	logic [15:0]           group_q;
	logic [1:0]            fill_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  discard_q;

	logic                  accept;
	logic                  closes;
	logic [1:0]            nbytes;
	logic [23:0]           word;
	logic [CMP_BITS-1:0]   sum;
	logic                  over;

	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;
	assign nbytes    = fill_q + 2'd1;
	assign closes    = (fill_q == 2'd2) || src_item.last_byte;

	// Left-align the group bytes in 24 bits
	always_comb begin
		unique case (fill_q)
			2'd0:    word = {src_item.data_byte, 16'h0000};
			2'd1:    word = {group_q[7:0], src_item.data_byte, 8'h00};
			default: word = {group_q, src_item.data_byte};
		endcase
	end

	// Check count plus one group against the capacity
	assign sum  = CMP_BITS'(count_q) + CMP_BITS'(4);
	assign over = (sum >= CMP_BITS'(capacity));

	assign push        = accept && !discard_q && closes;
	assign group.word   = word;
	assign group.nbytes = nbytes;
	assign group.last   = src_item.last_byte;
	assign group.err    = over;
	assign base         = count_q;

	// Advance group, count and discard state per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q   <= '0;
			fill_q    <= '0;
			count_q   <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			if (discard_q) begin
				if (src_item.last_byte) begin
					discard_q <= 1'b0;
					count_q   <= '0;
				end
			end else if (!closes) begin
				group_q <= {group_q[7:0], src_item.data_byte};
				fill_q  <= nbytes;
			end else begin
				group_q <= '0;
				fill_q  <= '0;
				if (src_item.last_byte) begin
					count_q <= '0;
				end else if (over) begin
					discard_q <= 1'b1;
				end else begin
					count_q <= count_q + COUNT_BITS'(4);
				end
			end
		end
	end

endmodule

// ----- rtl/b64e_queue.sv -----
// Short queue of classified groups between front and back.
module b64e_queue #(
	parameter int ENTRY_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [ENTRY_BITS-1:0] wr_data,
	input  logic                  pop,
	output logic [ENTRY_BITS-1:0] rd_data,
	output logic                  full,
	output logic                  nonempty
);

	localparam int DEPTH     = b64e_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	logic [ENTRY_BITS-1:0] mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   cnt_q;

	assign full     = (cnt_q == CNT_BITS'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue occupancy did not advance on write");
`endif

endmodule

// ----- rtl/b64e_back.sv -----
// Back end: expands groups to characters, one per unstalled cycle.
module b64e_back #(
	parameter int COUNT_BITS = b64e_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  b64e_pkg::group_t      head,
	input  logic [COUNT_BITS-1:0] head_base,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output b64e_pkg::out_item_t   res_item
);

	logic [1:0]            idx_q;
	logic                  res_valid_q;
	b64e_pkg::out_item_t   res_q;

	logic                  load;
	logic                  final_char;
	logic [5:0]            sextet;
	logic [COUNT_BITS-1:0] total;
	b64e_pkg::out_item_t   next_item;

	assign load       = q_valid && (!res_valid_q || res_ready);
	assign final_char = head.err || (idx_q == 2'd3);
	assign pop        = load && final_char;
	assign res_valid  = res_valid_q;
	assign res_item   = res_q;

	// Pick the sextet for the current character
	always_comb begin
		unique case (idx_q)
			2'd0:    sextet = head.word[23:18];
			2'd1:    sextet = head.word[17:12];
			2'd2:    sextet = head.word[11:6];
			default: sextet = head.word[5:0];
		endcase
	end

	// Build the next result
	always_comb begin
		total = head_base + COUNT_BITS'(idx_q) + COUNT_BITS'(1);
		next_item = '0;
		if (head.err) begin
			next_item.out_char       = b64e_pkg::CHAR_ERROR;
			next_item.end_of_message = 1'b1;
			next_item.overflow_error = 1'b1;
			next_item.total_chars    = b64e_pkg::TOTAL_BITS'(head_base);
		end else begin
			next_item.out_char       = (idx_q <= head.nbytes) ?
				b64e_pkg::b64_char(sextet) : b64e_pkg::CHAR_PAD;
			next_item.end_of_message = head.last && (idx_q == 2'd3);
			next_item.overflow_error = 1'b0;
			next_item.total_chars    = b64e_pkg::TOTAL_BITS'(total);
		end
	end

	// Hold the result register until taken, advance the character index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				idx_q       <= final_char ? 2'd0 : idx_q + 2'd1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= next_item;
		end
	end

`ifndef ASSERT_OFF
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.overflow_error) |->
			(res_q.end_of_message && res_q.out_char == b64e_pkg::CHAR_ERROR))
		else $error("error result without end of message");
	a_mid_group_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> q_valid)
		else $error("group left the queue before its last character");
	a_mid_group_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !head.err)
		else $error("error group expanded into several characters");
`endif

endmodule

// ----- rtl/base64_encoder_core.sv -----
// Top level of the streaming base64 encoder with output capacity check.
//
// Usage: message bytes enter on the src channel (src_valid/src_ready,
// src_item), one byte per item, with last_byte set on the final byte.
// Characters leave on the res channel (res_valid/res_ready, res_item), one
// per item: four per group of three bytes, a short final group padded with
// '='. If a group would bring the count plus four to output_capacity, one
// error item (out_char 0, overflow_error and end_of_message set) is given
// and the remaining bytes of that message are dropped.
// The first character of a group passes through the group queue and then the
// result register after the byte that completes the group is accepted.
// The character stage emits one character per cycle while res_ready allows,
// four characters for a full group of three bytes.
// A two-entry group queue lets bytes enter while characters still drain.
// Reset clears the partial group, the count and the queue; output_capacity
// returns to 16777215. When the receiver stalls, the held character stays
// on res_item, the queue fills and src_ready drops.
// output_capacity sits at APB address 0; the user must write it only while idle, the block does not enforce this.
module base64_encoder_core #(
	parameter int COUNT_BITS = b64e_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_ready,
	input  b64e_pkg::in_item_t               src_item,
	output logic                             res_valid,
	input  logic                             res_ready,
	output b64e_pkg::out_item_t              res_item,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [b64e_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [b64e_pkg::DATA_BITS-1:0]   pwdata,
	output logic [b64e_pkg::DATA_BITS-1:0]   prdata,
	output logic                             pready
);

	localparam int ENTRY_BITS = $bits(b64e_pkg::group_t) + COUNT_BITS;

	logic [b64e_pkg::CAP_BITS-1:0] capacity_q;
	logic                          cap_sel;

	logic                          push;
	logic                          pop;
	logic                          q_full;
	logic                          q_valid;
	b64e_pkg::group_t              wr_group;
	logic [COUNT_BITS-1:0]         wr_base;
	b64e_pkg::group_t              rd_group;
	logic [COUNT_BITS-1:0]         rd_base;
	logic [ENTRY_BITS-1:0]         rd_data;

	// Configuration register access
	assign pready  = 1'b1;
	assign cap_sel = (paddr[b64e_pkg::ADDR_BITS-1:2] == b64e_pkg::REG_OUTPUT_CAPACITY);
	assign prdata  = cap_sel ? b64e_pkg::DATA_BITS'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= b64e_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			capacity_q <= pwdata[b64e_pkg::CAP_BITS-1:0];
		end
	end

	b64e_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.capacity  (capacity_q),
		.q_full    (q_full),
		.push      (push),
		.group     (wr_group),
		.base      (wr_base)
	);

	b64e_queue #(
		.ENTRY_BITS (ENTRY_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  ({wr_group, wr_base}),
		.pop      (pop),
		.rd_data  (rd_data),
		.full     (q_full),
		.nonempty (q_valid)
	);

	assign rd_group = rd_data[ENTRY_BITS-1:COUNT_BITS];
	assign rd_base  = rd_data[COUNT_BITS-1:0];

	b64e_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (rd_group),
		.head_base (rd_base),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

// ----- dv/b64e_checker.sv -----
// Channel monitor for the base64 encoder: predicts every character item and compares.
module b64e_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	input  logic                             src_ready,
	input  b64e_pkg::in_item_t               src_item,
	input  logic                             res_valid,
	input  logic                             res_ready,
	input  b64e_pkg::out_item_t              res_item,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [b64e_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [b64e_pkg::DATA_BITS-1:0]   pwdata,
	input  logic [b64e_pkg::DATA_BITS-1:0]   prdata,
	input  logic                             pready,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [0:63][7:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [b64e_pkg::ADDR_BITS-1:0] CAPACITY_ADDR =
		{b64e_pkg::REG_OUTPUT_CAPACITY, 2'b00};

	// Shadow of the encoder state
	logic [b64e_pkg::CAP_BITS-1:0]   capacity;
	logic [15:0]                     held_bytes;
	logic [1:0]                      held_count;
	logic [b64e_pkg::TOTAL_BITS-1:0] msg_chars;
	logic                            dropping;
	b64e_pkg::out_item_t             due_chars[$];
	b64e_pkg::out_item_t             oldest_char;

	task automatic note_mismatch(input string msg);
		if (fail_count < 10) begin
			$display("%0t ns mismatch: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic clear_message();
		held_bytes = '0;
		held_count = '0;
		msg_chars  = '0;
		dropping   = 1'b0;
	endtask

	// Work out the character items that one accepted byte causes
	task automatic encode_byte(input b64e_pkg::in_item_t it);
		int                  nbytes;
		logic [31:0]         aligned;
		logic [23:0]         word;
		logic [5:0]          sextet;
		b64e_pkg::out_item_t ch;
		if (dropping) begin
			if (it.last_byte) begin
				clear_message();
			end
			return;
		end
		nbytes = held_count + 1;
		if (nbytes < 3 && !it.last_byte) begin
			held_bytes = {held_bytes[7:0], it.data_byte};
			held_count = nbytes[1:0];
			return;
		end
		// left-align a short group in the 24-bit word
		aligned = {8'h00, held_bytes, it.data_byte} << (8 * (3 - nbytes));
		word = aligned[23:0];
		if ({1'b0, msg_chars} + 25'd4 >= {1'b0, capacity}) begin
			ch.out_char       = b64e_pkg::CHAR_ERROR;
			ch.end_of_message = 1'b1;
			ch.overflow_error = 1'b1;
			ch.total_chars    = msg_chars;
			due_chars.push_back(ch);
			if (it.last_byte) begin
				clear_message();
			end else begin
				held_bytes = '0;
				held_count = '0;
				dropping   = 1'b1;
			end
			return;
		end
		for (int k = 0; k < 4; k++) begin
			sextet = 6'(word >> (18 - 6 * k));
			ch.out_char       = (k <= nbytes) ? ALPHABET[sextet] : b64e_pkg::CHAR_PAD;
			msg_chars         = msg_chars + 1'b1;
			ch.end_of_message = it.last_byte && (k == 3);
			ch.overflow_error = 1'b0;
			ch.total_chars    = msg_chars;
			due_chars.push_back(ch);
		end
		held_bytes = '0;
		held_count = '0;
		if (it.last_byte) begin
			clear_message();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = b64e_pkg::CAP_RESET;
			clear_message();
			due_chars.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// compare a delivered character with the oldest one due
			if (res_valid && res_ready) begin
				if (due_chars.size() == 0) begin
					note_mismatch($sformatf("unexpected item char=%h eom=%b err=%b total=%0d",
						res_item.out_char, res_item.end_of_message,
						res_item.overflow_error, res_item.total_chars));
				end else begin
					oldest_char = due_chars.pop_front();
					if (res_item !== oldest_char) begin
						note_mismatch($sformatf(
							"want char=%h eom=%b err=%b total=%0d, got char=%h eom=%b err=%b total=%0d",
							oldest_char.out_char, oldest_char.end_of_message,
							oldest_char.overflow_error, oldest_char.total_chars,
							res_item.out_char, res_item.end_of_message,
							res_item.overflow_error, res_item.total_chars));
					end
				end
			end
			// predict from an accepted byte
			if (src_valid && src_ready) begin
				encode_byte(src_item);
			end
			// track register writes and check reads
			if (psel && penable && pready && paddr == CAPACITY_ADDR) begin
				if (pwrite) begin
					capacity = pwdata[b64e_pkg::CAP_BITS-1:0];
				end else if (prdata[b64e_pkg::CAP_BITS-1:0] !== capacity) begin
					note_mismatch($sformatf("capacity read want %0d, got %0d",
						capacity, prdata[b64e_pkg::CAP_BITS-1:0]));
				end
			end
			pending = due_chars.size();
		end
	end

endmodule

// ----- dv/tb_base64_encoder_core.sv -----
// Top of the base64 encoder testbench: clock, reset, stimulus and verdict.
module tb_base64_encoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [b64e_pkg::ADDR_BITS-1:0] CAPACITY_ADDR =
		{b64e_pkg::REG_OUTPUT_CAPACITY, 2'b00};
	localparam logic [b64e_pkg::ADDR_BITS-1:0] UNUSED_ADDR   = 3'd4;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           src_valid = 1'b0;
	logic                           src_ready;
	b64e_pkg::in_item_t             src_item  = '0;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	b64e_pkg::out_item_t            res_item;
	logic                           psel      = 1'b0;
	logic                           penable   = 1'b0;
	logic                           pwrite    = 1'b0;
	logic [b64e_pkg::ADDR_BITS-1:0] paddr     = '0;
	logic [b64e_pkg::DATA_BITS-1:0] pwdata    = '0;
	logic [b64e_pkg::DATA_BITS-1:0] prdata;
	logic                           pready;

	int         fail_count;
	int         pending;
	bit         calm       = 1'b0;
	bit         steady     = 1'b0;
	int         stall_left = 0;
	int         steady_left = 0;
	int         items_sent = 0;
	logic [7:0] msg_bytes[$];

	base64_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	b64e_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.src_item   (src_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Stall the receiver in short bursts, with steady stretches in between
	always @(posedge clk) begin
		if (steady_left == 0) begin
			steady <= !steady;
			steady_left <= $urandom_range(20, 80);
		end else begin
			steady_left <= steady_left - 1;
		end
		if (calm || steady) begin
			res_ready <= 1'b1;
		end else if (stall_left != 0) begin
			res_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			res_ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Drop valid, wait until every due character has come, then let the block settle
	task automatic wait_idle();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [b64e_pkg::ADDR_BITS-1:0] addr,
			input logic [b64e_pkg::DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write the capacity with junk in the unused upper bits, then read it back
	task automatic set_capacity(input logic [b64e_pkg::CAP_BITS-1:0] cap);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		wait_idle();
		apb_access(1'b1, CAPACITY_ADDR, {junk, cap});
		apb_access(1'b0, CAPACITY_ADDR, '0);
	endtask

	// Offer one byte and hold it until accepted
	task automatic push_byte(input logic [7:0] b, input logic last);
		if (!calm && !steady && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= '{data_byte: b, last_byte: last};
		do @(posedge clk); while (!src_ready);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++) begin
			push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
			items_sent++;
			// now and then hold the sender mid-message until the output drains
			if (!calm && i != msg_bytes.size() - 1 &&
					(items_sent == 60 || $urandom_range(0, 39) == 0)) begin
				wait_idle();
			end
		end
	endtask

	task automatic make_message();
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
		msg_bytes.delete();
		for (int i = 0; i < len; i++) begin
			msg_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	function automatic logic [b64e_pkg::CAP_BITS-1:0] pick_capacity();
		case ($urandom_range(0, 5))
			0:       return b64e_pkg::CAP_RESET;
			1:       return '0;
			2:       return b64e_pkg::CAP_BITS'($urandom_range(1, 8));
			5:       return b64e_pkg::CAP_BITS'($urandom_range(0, 24'hFFFFFF));
			default: return b64e_pkg::CAP_BITS'($urandom_range(5, 30));
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();
		apb_access(1'b0, CAPACITY_ADDR, '0);

		// one-, two- and three-byte groups, and a group followed by a short one
		msg_bytes = '{8'h00};
		send_message();
		msg_bytes = '{8'hFF, 8'hFF};
		send_message();
		msg_bytes = '{8'h4D, 8'h61, 8'h6E};
		send_message();
		msg_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00};
		send_message();

		// zero capacity: error on a last group, then error and drop of the rest
		set_capacity('0);
		msg_bytes = '{8'hA5};
		send_message();
		msg_bytes = '{8'h01, 8'h02, 8'h03, 8'h80};
		send_message();

		// write to an address with no register, then overflow on the final group
		wait_idle();
		apb_access(1'b1, UNUSED_ADDR, '0);
		set_capacity(24'd9);
		msg_bytes = '{8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE, 8'h7F};
		send_message();

		// random messages under changing capacities
		set_capacity(b64e_pkg::CAP_RESET);
		while (items_sent < 175) begin
			if ($urandom_range(0, 3) == 0) begin
				set_capacity(pick_capacity());
			end
			if (items_sent >= 145) begin
				calm = 1'b1;
			end
			make_message();
			send_message();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
